FILE: sv/text_console_writer_macros.svh
// Assertion macros for the text console writer RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tcw_pkg.sv
// Shared types, constants and controller/datapath interface structs for the text console writer.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] DEFAULT_ATTR = 8'h07;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic       scrolled;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_BLANK,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic take;
        logic exec;
        logic clear_wr;
        logic blank_wr;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic blank_last;
        logic scroll;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/tcw_ctrl.sv
// Controller state machine for the text console writer.
// Depends on tcw_pkg; drives datapath commands and the input stall.
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.scroll ? S_BLANK : S_RESULT;
            end
            S_BLANK: begin
                o_cmd.blank_wr = 1'b1;
                if (i_status.blank_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // Hold the finished beat until the output register can take it.
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: sv/tcw_datapath.sv
// Datapath of the text console writer: screen memory, cursor, scroll offset and output register.
// Depends on tcw_pkg; sequenced by tcw_ctrl.
`timescale 1ns / 1ps

module tcw_datapath
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  t_in_item   i_in,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out
);

    // The screen is a ring of rows: r_top is the physical row shown as row 0,
    // so a scroll only moves r_top and blanks one row.
    logic [15:0]       r_screen [CELL_COUNT];
    t_in_item          r_item;
    logic [7:0]        r_attr;
    logic [ROW_W-1:0]  r_top;
    logic [ROW_W-1:0]  r_cur_row;
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_blank_row;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_scrolled;
    logic [15:0]       r_rd_data;
    logic              r_rd_ok;
    t_out_item         r_out;
    logic              r_out_valid;

    logic [ROW_W-1:0]  n_cur_row;
    logic [COL_W-1:0]  n_cur_col;
    logic              put_scroll;
    logic              put_store;
    logic              rd_ok;
    logic              is_put;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              col_last;
    logic              row_last;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(32'(prow) * COLUMNS + 32'(col));
    endfunction

    assign is_put   = (r_item.command == CMD_PUT);
    assign col_last = (r_cur_col == COL_W'(COLUMNS - 1));
    assign row_last = (r_cur_row == ROW_W'(ROWS - 1));
    assign rd_ok    = (32'(r_item.read_row) < ROWS) && (32'(r_item.read_col) < COLUMNS);

    always_comb begin
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        put_scroll = 1'b0;
        put_store  = 1'b0;
        if (r_item.char_code == CH_NEWLINE) begin
            put_scroll = row_last;
            n_cur_row  = r_cur_row + ROW_W'(1);
            n_cur_col  = '0;
        end else if (r_item.char_code == CH_RETURN) begin
            n_cur_col = '0;
        end else begin
            put_store = 1'b1;
            if (col_last) begin
                put_scroll = row_last;
                n_cur_row  = r_cur_row + ROW_W'(1);
                n_cur_col  = '0;
            end else begin
                n_cur_col = r_cur_col + COL_W'(1);
            end
        end
        if (put_scroll) begin
            n_cur_row = ROW_W'(ROWS - 1);
            n_cur_col = '0;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = {DEFAULT_ATTR, CH_SPACE};
        if (i_cmd.clear_wr) begin
            mem_we = 1'b1;
        end else if (i_cmd.blank_wr) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(r_blank_row, COL_W'(r_cnt));
            mem_wdata = {r_attr, CH_SPACE};
        end else if (i_cmd.exec && is_put && put_store) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(phys_row(r_cur_row, r_top), r_cur_col);
            mem_wdata = {r_attr, r_item.char_code};
        end
    end

    assign mem_raddr = cell_addr(phys_row(ROW_W'(r_item.read_row), r_top),
                                 COL_W'(r_item.read_col));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_screen[mem_raddr];
    end

    assign o_status.clear_last = (r_cnt == ADDR_W'(CELL_COUNT - 1));
    assign o_status.blank_last = (r_cnt == ADDR_W'(COLUMNS - 1));
    assign o_status.scroll     = is_put && put_scroll;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_in;
        end
        if (i_cmd.exec) begin
            r_rd_ok    <= rd_ok;
            r_scrolled <= is_put && put_scroll;
            if (put_scroll) begin
                r_blank_row <= r_top;
            end
        end
        if (i_cmd.load_out) begin
            r_out.cell_char  <= (!is_put && r_rd_ok) ? r_rd_data[7:0] : 8'd0;
            r_out.cell_attr  <= (!is_put && r_rd_ok) ? r_rd_data[15:8] : 8'd0;
            r_out.cursor_row <= 5'(r_cur_row);
            r_out.cursor_col <= 7'(r_cur_col);
            r_out.scrolled   <= r_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= DEFAULT_ATTR;
            r_top       <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.exec && is_put) begin
                r_cur_row <= n_cur_row;
                r_cur_col <= n_cur_col;
                if (put_scroll) begin
                    r_top <= phys_row(ROW_W'(1), r_top);
                end
            end
            if (i_cmd.clear_wr) begin
                r_cnt <= o_status.clear_last ? '0 : r_cnt + ADDR_W'(1);
            end else if (i_cmd.blank_wr) begin
                r_cnt <= o_status.blank_last ? '0 : r_cnt + ADDR_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: sv/text_console_writer.sv
// Text console writer, 25 by 80 cells, with a cursor, scrolling and cell reads.
// o_out_valid rises once an accepted read or put has passed the EXEC and RESULT states and
// the output register; a put that scrolls first blanks the 80 cells of the bottom row in BLANK.
// The block takes one item at a time, accepting a new one only back in IDLE; a result beat held
// by i_out_stall keeps the next item out until the output register frees.
// Reset: synchronous; a clearing pass then writes all 2000 cells, one per cycle, stalling input.
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module text_console_writer
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       out_cursor_ok;
    logic       out_at_bottom_start;
    logic       out_cell_empty;

    // User must write the attribute only while the block is idle; unenforced, so always ready.
    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    tcw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    assign out_cursor_ok       = (32'(o_out.cursor_row) < ROWS) &&
                                 (32'(o_out.cursor_col) < COLUMNS);
    assign out_at_bottom_start = (o_out.cursor_row == 5'(ROWS - 1)) &&
                                 (o_out.cursor_col == 7'd0);
    assign out_cell_empty      = (o_out.cell_char == 8'd0) && (o_out.cell_attr == 8'd0);

    `TCW_ASSERT_NXT(a_stall_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input accepted twice")
    `TCW_ASSERT_IMP(a_cursor_in_range, o_out_valid, out_cursor_ok, "cursor out of range")
    `TCW_ASSERT_IMP(a_scroll_cursor, o_out_valid && o_out.scrolled, out_at_bottom_start, "scroll cursor")
    `TCW_ASSERT_IMP(a_scroll_no_cell, o_out_valid && o_out.scrolled, out_cell_empty, "put with cell data")

endmodule

FILE: dv/text_console_writer_checker.sv
// Checker for the text console writer: watches the input, result and attribute channels,
// keeps its own copy of the screen, cursor and attribute, and compares every result beat.
// Depends on tcw_pkg for the beat types and screen geometry.
`timescale 1ns / 1ps

module text_console_writer_checker
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int MAX_REPORTS = 10;

    logic [15:0] screen [CELL_COUNT];
    int unsigned cursor;
    logic [7:0]  attr;
    t_out_item   console_results[$];
    int          fail_count = 0;

    function automatic string beat_text(input t_out_item b);
        return $sformatf("char=%0d attr=%0d row=%0d col=%0d scrolled=%0d",
                         b.cell_char, b.cell_attr, b.cursor_row, b.cursor_col, b.scrolled);
    endfunction

    // Applies one command to the screen copy and returns the beat it should produce.
    function automatic t_out_item console_step(input t_in_item item);
        t_out_item   res;
        int unsigned row;
        int unsigned idx;
        res = '0;
        if (item.command == CMD_READ) begin
            if (item.read_row < ROWS && item.read_col < COLUMNS) begin
                idx = item.read_row * COLUMNS + item.read_col;
                res.cell_char = screen[idx][7:0];
                res.cell_attr = screen[idx][15:8];
            end
        end else begin
            row = cursor / COLUMNS;
            if (item.char_code == CH_NEWLINE) begin
                cursor = (row + 1) * COLUMNS;
            end else if (item.char_code == CH_RETURN) begin
                cursor = row * COLUMNS;
            end else begin
                screen[cursor] = {attr, item.char_code};
                cursor++;
            end
            // Passing the last cell moves every row up and blanks the bottom one.
            if (cursor >= CELL_COUNT) begin
                for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                    screen[i] = screen[i + COLUMNS];
                end
                for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                    screen[i] = {attr, CH_SPACE};
                end
                cursor = CELL_COUNT - COLUMNS;
                res.scrolled = 1'b1;
            end
        end
        res.cursor_row = 5'(cursor / COLUMNS);
        res.cursor_col = 7'(cursor % COLUMNS);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                screen[i] = {DEFAULT_ATTR, CH_SPACE};
            end
            cursor = 0;
            attr   = DEFAULT_ATTR;
            console_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                attr = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                console_results.push_back(console_step(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (console_results.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("unexpected result beat at %0t: %s", $realtime,
                                 beat_text(i_out));
                    end
                    fail_count++;
                end else begin
                    want = console_results.pop_front();
                    if (i_out.cell_char !== want.cell_char ||
                        i_out.cell_attr !== want.cell_attr ||
                        i_out.cursor_row !== want.cursor_row ||
                        i_out.cursor_col !== want.cursor_col ||
                        i_out.scrolled !== want.scrolled) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("result mismatch at %0t: expected %s, actual %s",
                                     $realtime, beat_text(want), beat_text(i_out));
                        end
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= console_results.size();
    end

endmodule

FILE: dv/tb_text_console_writer.sv
// Testbench top for the text console writer: clock, reset, command and attribute stimulus,
// random stalls on the result side, and the final verdict.
// Depends on tcw_pkg, the text_console_writer RTL and text_console_writer_checker.
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 100;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = '0;
    logic       in_stall;
    logic       out_valid;
    logic       cfg_ready;
    t_out_item  out_item;
    int         fail_count;
    int         pending;
    int         hold_requests = 0;
    int         idle_pct      = 0;
    int         items_sent    = 0;
    int         cycle_count   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_console_writer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    text_console_writer_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off when the stimulus asks.
    initial begin : result_stalls
        int holds_served;
        int span;
        holds_served = 0;
        forever begin
            @(posedge clk);
            if (hold_requests > holds_served) begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(1, 100) <= idle_pct) begin
                span = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (span) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Valid stays high from one beat to the next unless a gap is taken.
    task automatic send_item(input t_in_item item);
        int gap;
        if ($urandom_range(1, 100) <= idle_pct) begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic put_char(input logic [7:0] code);
        t_in_item item;
        item.command   = CMD_PUT;
        item.char_code = code;
        item.read_row  = 5'($urandom);
        item.read_col  = 7'($urandom);
        send_item(item);
    endtask

    task automatic read_cell(input int row, input int col);
        t_in_item item;
        item.command   = CMD_READ;
        item.char_code = 8'($urandom);
        item.read_row  = 5'(row);
        item.read_col  = 7'(col);
        send_item(item);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] text_byte();
        return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(32, 126)) : 8'($urandom);
    endfunction

    // Mostly short lines; now and then one long enough to wrap past the row end.
    task automatic type_line();
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 30);
        repeat (len) put_char(text_byte());
        case ($urandom_range(0, 3))
            0: begin
                put_char(CH_RETURN);
            end
            1: begin
                put_char(CH_RETURN);
                put_char(CH_NEWLINE);
            end
            default: begin
                put_char(CH_NEWLINE);
            end
        endcase
    endtask

    task automatic read_burst();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 6) != 0) begin
                read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
            end else if ($urandom_range(0, 1) == 0) begin
                read_cell($urandom_range(ROWS, 31), $urandom_range(0, 127));
            end else begin
                read_cell($urandom_range(0, 31), $urandom_range(COLUMNS, 127));
            end
        end
    endtask

    initial begin : stimulus
        int phase_end;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Fresh screen, including reads outside the screen.
        read_cell(0, 0);
        read_cell(ROWS - 1, COLUMNS - 1);
        read_cell(ROWS, 0);
        read_cell(0, COLUMNS);
        read_cell(31, 127);

        drain_results();
        write_attribute(8'hFF);
        put_char(8'h48);
        put_char(8'h00);
        put_char(8'hFF);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
        put_char(CH_RETURN);
        put_char(8'h78);
        read_cell(0, 0);
        put_char(CH_NEWLINE);

        // Walk down to the bottom row, then a newline there must scroll.
        drain_results();
        write_attribute(8'h00);
        repeat (ROWS - 2) put_char(CH_NEWLINE);
        put_char(8'h7A);
        put_char(CH_NEWLINE);
        read_cell(ROWS - 2, 0);
        read_cell(ROWS - 1, 0);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            write_attribute(phase == PHASES - 1 ? DEFAULT_ATTR : 8'($urandom));
            idle_pct <= (phase == PHASES - 1) ? 0 : $urandom_range(10, 40);
            if (phase == 1) begin
                hold_requests <= hold_requests + 1;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) < 7) begin
                    type_line();
                end else begin
                    read_burst();
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
